@@ src/rgb_to_hsv_pixel_top_assert.svh @@
// Assertion macros used by the top module of the HSV converter.
`ifndef RGB_TO_HSV_PIXEL_TOP_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RTH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RTH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rth_pkg.sv @@
package rth_pkg;

    // Divider geometry: one quotient bit per cell
    localparam int NumCells = 9;
    localparam int QuoW     = NumCells;
    localparam int DenW     = 17;     // 9-bit doubled divisor aligned to the top bit
    localparam int RemW     = 18;     // doubled, biased numerator

    // Scale factors of the rounded quotients (numerator doubled for rounding)
    localparam logic [RemW-1:0] HueScale = RemW'(120);
    localparam logic [RemW-1:0] PctScale = RemW'(200);
    localparam logic [RemW-1:0] BriBias  = RemW'(255);
    localparam logic [8:0]      BriDen   = 9'd510;

    // One restoring division in flight
    typedef struct packed {
        logic [RemW-1:0] rem;
        logic [DenW-1:0] dsh;
        logic [QuoW-1:0] quo;
    } lane_t;

    // Everything one pixel carries through the chain
    typedef struct packed {
        lane_t hue;
        lane_t sat;
        lane_t bri;
        logic  sat_en;
    } work_t;

    // One compare-subtract step; the divisor moves one bit down for the next cell
    function automatic lane_t div_step(lane_t a);
        lane_t r;
        logic  ge;
        ge    = a.rem >= {1'b0, a.dsh};
        r.rem = ge ? (a.rem - {1'b0, a.dsh}) : a.rem;
        r.dsh = a.dsh >> 1;
        r.quo = {a.quo[QuoW-2:0], ge};
        return r;
    endfunction

endpackage

@@ src/rth_pix_if.sv @@
interface rth_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ src/rth_hsv_if.sv @@
interface rth_hsv_if;
    logic       valid;
    logic       ready;
    logic [8:0] hue_degrees;
    logic [6:0] saturation_pct;
    logic [6:0] brightness_pct;

    modport source (output valid, output hue_degrees, output saturation_pct,
                    output brightness_pct, input ready);
    modport sink   (input valid, input hue_degrees, input saturation_pct,
                    input brightness_pct, output ready);
endinterface

@@ src/rth_prep.sv @@
module rth_prep
    import rth_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       out_valid,
    input  logic       out_ready,
    output work_t      out_data
);

    logic        valid_reg;
    logic        valid_next;
    work_t       data_reg;
    work_t       data_next;
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  delta;
    logic [10:0] d2;
    logic [10:0] d4;
    logic [10:0] d6;
    logic [10:0] sector;
    logic        load;

    // Channel extremes
    always_comb
    begin
        mx = red;
        mn = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        delta = mx - mn;
        d2    = {2'b0, delta, 1'b0};
        d4    = {1'b0, delta, 2'b0};
        d6    = d4 + d2;
    end

    // Hue sector term times delta, always in 0..6*delta; red wins ties, then green
    always_comb
    begin
        priority if (mx == red)
        begin
            sector = {3'b0, green} - {3'b0, blue} + ((green < blue) ? d6 : 11'd0);
        end
        else if (mx == green)
        begin
            sector = {3'b0, blue} - {3'b0, red} + d2;
        end
        else
        begin
            sector = {3'b0, red} - {3'b0, green} + d4;
        end
    end

    // Load the three dividers: numerators doubled plus divisor for rounding
    always_comb
    begin
        data_next.hue.rem = RemW'(sector) * HueScale + RemW'(delta);
        data_next.hue.dsh = (delta == 8'd0) ? {DenW{1'b1}} : {delta, 9'b0};
        data_next.hue.quo = '0;
        data_next.sat.rem = RemW'(delta) * PctScale + RemW'(mx);
        data_next.sat.dsh = (mx == 8'd0) ? {DenW{1'b1}} : {mx, 9'b0};
        data_next.sat.quo = '0;
        data_next.bri.rem = RemW'(mx) * PctScale + BriBias;
        data_next.bri.dsh = {BriDen, 8'b0};
        data_next.bri.quo = '0;
        // brightness rounds to zero exactly when max is below two
        data_next.sat_en  = mx > 8'd1;
    end

    // Stage handshake
    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ src/rth_cell.sv @@
module rth_cell
    import rth_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  work_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output work_t out_data
);

    logic  valid_reg;
    logic  valid_next;
    work_t data_reg;
    work_t data_next;
    logic  load;

    // One quotient bit for each of the three divisions
    always_comb
    begin
        data_next.hue    = div_step(in_data.hue);
        data_next.sat    = div_step(in_data.sat);
        data_next.bri    = div_step(in_data.bri);
        data_next.sat_en = in_data.sat_en;
    end

    // Take a beat when empty or when the neighbor drains this one
    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ src/rgb_to_hsv_pixel_top.sv @@
// RGB888 to HSV converter.
// pixel (sink): red, green, blue bytes, one beat per pixel.
// hsv (source): hue_degrees 0..360, saturation_pct 0..100, brightness_pct
//   0..100, all rounded half away from zero; one beat per pixel, in order.
// Gray pixels give hue 0; pixels whose brightness rounds to 0 give saturation 0.
// Structure: one input stage finds max, min and the hue sector, then a row of
// nine identical cells runs three restoring divisions side by side, one
// quotient bit per cell per cycle while the receiver does not stall.
// Each pixel passes the input stage register, then the nine cell registers.
// Throughput: one pixel per cycle while the receiver keeps hsv.ready high.
// Every stage has its own valid bit, so bubbles collapse: a stage takes a new
// beat when it is empty or its neighbor drains it. When the receiver stalls,
// the result holds stable on hsv and the row keeps filling until all ten
// stages are full, then pixel.ready drops.
// Reset clears all valid bits; no result is pending after reset.
`include "rgb_to_hsv_pixel_top_assert.svh"

module rgb_to_hsv_pixel_top
    import rth_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rth_pix_if.sink    pixel,
    rth_hsv_if.source  hsv
);

    logic  vld [NumCells+1];
    logic  rdy [NumCells+1];
    work_t dat [NumCells+1];
    work_t last;

    // Input stage
    rth_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .red       (pixel.red),
        .green     (pixel.green),
        .blue      (pixel.blue),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_data  (dat[0])
    );

    // Divider row
    for (genvar k = 0; k < NumCells; k++)
    begin : g_cell
        rth_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[k]),
            .in_ready  (rdy[k]),
            .in_data   (dat[k]),
            .out_valid (vld[k+1]),
            .out_ready (rdy[k+1]),
            .out_data  (dat[k+1])
        );
    end

    // Result beat straight from the last cell's register
    assign last                = dat[NumCells];
    assign rdy[NumCells]       = hsv.ready;
    assign hsv.valid           = vld[NumCells];
    assign hsv.hue_degrees     = last.hue.quo;
    assign hsv.saturation_pct  = last.sat_en ? last.sat.quo[6:0] : 7'd0;
    assign hsv.brightness_pct  = last.bri.quo[6:0];

    `RTH_ASSERT_NOW(a_hue_range, hsv.valid, hsv.hue_degrees <= 9'd360,
        "hue out of range")
    `RTH_ASSERT_NOW(a_pct_range, hsv.valid,
        (last.sat.quo <= 9'd100 || !last.sat_en) && last.bri.quo <= 9'd100,
        "percentage out of range")
    `RTH_ASSERT_NEXT(a_stall_hold, hsv.valid && !hsv.ready,
        hsv.valid && $stable(hsv.hue_degrees) && $stable(hsv.saturation_pct)
        && $stable(hsv.brightness_pct), "stalled result changed")
    `RTH_ASSERT_NOW(a_dark_sat, hsv.valid && hsv.brightness_pct == 7'd0,
        hsv.saturation_pct == 7'd0, "dark pixel with nonzero saturation")

endmodule
